[src/perl_lexical_scanner_defines.svh]
// Assertion macros shared by the scanner modules.
`ifndef PERL_LEXICAL_SCANNER_DEFINES_SVH
`define PERL_LEXICAL_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pls_pkg.sv]
// Shared types, constants and character-class helpers of the Perl lexical scanner.
package pls_pkg;

  // Here-document terminator storage and brace depth counter sizes
  localparam int MARKER_LEN = 32;
  localparam int DEPTH_BITS = 16;
  localparam int MK_IDX_W   = $clog2(MARKER_LEN);
  localparam int MK_POS_W   = $clog2(MARKER_LEN + 2);

  // Character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_B  = 8'h62;

  typedef enum logic [13:0] {
    SC_CODE        = 14'b00000000000001,
    SC_STRING      = 14'b00000000000010,
    SC_QSTRING     = 14'b00000000000100,
    SC_RE_OPTS     = 14'b00000000001000,
    SC_COMMENT     = 14'b00000000010000,
    SC_COMMAND     = 14'b00000000100000,
    SC_VAR1        = 14'b00000001000000,
    SC_VARBODY     = 14'b00000010000000,
    SC_HD1         = 14'b00000100000000,
    SC_HD2         = 14'b00001000000000,
    SC_HDSTART     = 14'b00010000000000,
    SC_HD          = 14'b00100000000000,
    SC_HDSTARTLINE = 14'b01000000000000,
    SC_HDCHECK     = 14'b10000000000000
  } scan_state_t;

  typedef enum logic [5:0] {
    SUB_IDLE    = 6'b000001,
    SUB_KEYWORD = 6'b000010,
    SUB_LEAD    = 6'b000100,
    SUB_NAME    = 6'b001000,
    SUB_TRAIL   = 6'b010000,
    SUB_BODY    = 6'b100000
  } sub_state_t;

  // One input beat
  typedef struct packed {
    logic [7:0]  ch;
    logic [31:0] char_position;
    logic [15:0] page;
    logic        restart;
  } pls_item_t;

  // Lexer events handed to the sub tracker
  typedef struct packed {
    logic italic;
    logic code_nxt;
    logic brace_open;
    logic brace_close;
  } pls_lex_evt_t;

  // One result beat
  typedef struct packed {
    logic        italic;
    logic        func_open;
    logic [31:0] name_start;
    logic [31:0] name_end;
    logic [15:0] name_page;
    logic        func_close;
  } pls_result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

  // Letters of the sub keyword
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_LOW_S;
      2'd1:    c = CH_LOW_U;
      2'd2:    c = CH_LOW_B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/pls_marker_ram.sv]
// Terminator word store with prefetched, write-through registered read.
module pls_marker_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pls_pkg::MK_IDX_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [pls_pkg::MK_IDX_W-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [pls_pkg::MARKER_LEN];
  logic [7:0] rdata_r;

  // Write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read every cycle, forwarding a same-address write
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/pls_lexer.sv]
// Lexical state machine: quoting, comments, escapes and here-document matching.
module pls_lexer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pls_pkg::pls_item_t    item,
  output pls_pkg::pls_lex_evt_t evt
);

  pls_pkg::scan_state_t          scan_r, scan_nxt, st;
  logic                          esc_r, esc_nxt, esc;
  logic [pls_pkg::MK_POS_W-1:0]  mpos_r, mpos_nxt, mpos, mpos_p1;
  logic [pls_pkg::MK_POS_W-1:0]  mcnt_r, mcnt_nxt, mcnt;
  logic                          run;
  logic                          wr_en;
  logic [pls_pkg::MK_IDX_W-1:0]  wr_addr;
  logic [pls_pkg::MK_IDX_W-1:0]  rd_addr;
  logic [7:0]                    mk_rd;
  logic [7:0]                    c;
  logic                          is_quote;
  logic                          hit;
  pls_pkg::scan_state_t          chk_scan;
  logic [pls_pkg::MK_POS_W-1:0]  chk_pos;

  assign c = item.ch;

  // Take reset values when the beat asks for a restart
  always_comb begin
    st   = item.restart ? pls_pkg::SC_CODE : scan_r;
    esc  = item.restart ? 1'b0 : esc_r;
    mpos = item.restart ? '0 : mpos_r;
    mcnt = item.restart ? '0 : mcnt_r;
  end

  assign mpos_p1  = mpos + 1'b1;
  assign is_quote = (c == pls_pkg::CH_DQUOTE) || (c == pls_pkg::CH_SQUOTE);

  // Compare a line byte against the stored terminator
  always_comb begin
    hit = (mpos < mcnt) && (mpos < pls_pkg::MK_POS_W'(pls_pkg::MARKER_LEN)) && (c == mk_rd);
    if (hit) begin
      chk_scan = pls_pkg::SC_HDCHECK;
      chk_pos  = mpos_p1;
    end else if ((mpos == mcnt) && (c == pls_pkg::CH_LF)) begin
      chk_scan = pls_pkg::SC_CODE;
      chk_pos  = mpos_p1;
    end else begin
      chk_scan = pls_pkg::SC_HD;
      chk_pos  = '0;
    end
  end

  // Next lexical state
  always_comb begin
    scan_nxt   = st;
    esc_nxt    = esc;
    mpos_nxt   = mpos;
    mcnt_nxt   = mcnt;
    wr_en      = 1'b0;
    wr_addr    = '0;
    run        = 1'b1;
    evt        = '0;

    // Consume or raise a pending escape
    case (st)
      pls_pkg::SC_CODE, pls_pkg::SC_STRING, pls_pkg::SC_QSTRING,
      pls_pkg::SC_COMMAND, pls_pkg::SC_VARBODY: begin
        if (esc) begin
          esc_nxt = 1'b0;
          run     = 1'b0;
        end else if (c == pls_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
          run     = 1'b0;
        end
      end
      pls_pkg::SC_HD1, pls_pkg::SC_HD2, pls_pkg::SC_VAR1, pls_pkg::SC_HDSTART: begin
        if ((c == pls_pkg::CH_BSLASH) && !esc) begin
          esc_nxt = 1'b1;
          run     = 1'b0;
        end
      end
      default: ;
    endcase

    if (run) begin
      case (st)
        pls_pkg::SC_CODE: begin
          case (c)
            pls_pkg::CH_DOLLAR: scan_nxt = pls_pkg::SC_VAR1;
            pls_pkg::CH_DQUOTE: scan_nxt = pls_pkg::SC_STRING;
            pls_pkg::CH_SQUOTE: scan_nxt = pls_pkg::SC_QSTRING;
            pls_pkg::CH_BTICK:  scan_nxt = pls_pkg::SC_COMMAND;
            pls_pkg::CH_HASH: begin
              scan_nxt   = pls_pkg::SC_COMMENT;
              evt.italic = 1'b1;
            end
            pls_pkg::CH_LT:     scan_nxt = pls_pkg::SC_HD1;
            pls_pkg::CH_LBRACK: scan_nxt = pls_pkg::SC_RE_OPTS;
            pls_pkg::CH_LBRACE: evt.brace_open = 1'b1;
            pls_pkg::CH_RBRACE: evt.brace_close = 1'b1;
            default: ;
          endcase
        end
        pls_pkg::SC_STRING:  if (c == pls_pkg::CH_DQUOTE) scan_nxt = pls_pkg::SC_CODE;
        pls_pkg::SC_RE_OPTS: if (c == pls_pkg::CH_RBRACK) scan_nxt = pls_pkg::SC_CODE;
        pls_pkg::SC_QSTRING: if (c == pls_pkg::CH_SQUOTE) scan_nxt = pls_pkg::SC_CODE;
        pls_pkg::SC_COMMAND: if (c == pls_pkg::CH_BTICK) scan_nxt = pls_pkg::SC_CODE;
        pls_pkg::SC_COMMENT: begin
          evt.italic = 1'b1;
          if (c == pls_pkg::CH_LF) scan_nxt = pls_pkg::SC_CODE;
        end
        pls_pkg::SC_VAR1: begin
          if (esc) begin
            esc_nxt  = 1'b0;
            scan_nxt = pls_pkg::SC_CODE;
          end else if (c == pls_pkg::CH_LBRACE) begin
            scan_nxt = pls_pkg::SC_VARBODY;
          end else begin
            scan_nxt = pls_pkg::SC_CODE;
          end
        end
        pls_pkg::SC_HD1: begin
          if (esc) begin
            esc_nxt  = 1'b0;
            scan_nxt = pls_pkg::SC_CODE;
          end else if (c == pls_pkg::CH_LT) begin
            scan_nxt = pls_pkg::SC_HD2;
          end else begin
            scan_nxt = pls_pkg::SC_CODE;
          end
        end
        pls_pkg::SC_VARBODY: if (c == pls_pkg::CH_RBRACE) scan_nxt = pls_pkg::SC_CODE;
        pls_pkg::SC_HD2: begin
          // Store the first terminator byte
          if ((esc || ((c != pls_pkg::CH_DASH) && !pls_pkg::is_space(c))) && !is_quote) begin
            esc_nxt  = 1'b0;
            mpos_nxt = '0;
            wr_en    = 1'b1;
            wr_addr  = '0;
            scan_nxt = pls_pkg::SC_HDSTART;
          end
        end
        pls_pkg::SC_HDSTART: begin
          if ((esc || !pls_pkg::is_space(c)) && !is_quote) begin
            // Append a terminator byte, drop it once the store is full
            esc_nxt = 1'b0;
            if (mpos_p1 < pls_pkg::MK_POS_W'(pls_pkg::MARKER_LEN)) begin
              mpos_nxt = mpos_p1;
              wr_en    = 1'b1;
              wr_addr  = mpos_p1[pls_pkg::MK_IDX_W-1:0];
            end
          end else begin
            mcnt_nxt = mpos_p1;
            mpos_nxt = '0;
            scan_nxt = pls_pkg::SC_HD;
          end
        end
        pls_pkg::SC_HD: if (c == pls_pkg::CH_LF) scan_nxt = pls_pkg::SC_HDSTARTLINE;
        pls_pkg::SC_HDSTARTLINE: begin
          if (!pls_pkg::is_space(c)) begin
            scan_nxt = pls_pkg::SC_HDCHECK;
            if (!is_quote) begin
              scan_nxt = chk_scan;
              mpos_nxt = chk_pos;
            end
          end
        end
        pls_pkg::SC_HDCHECK: begin
          if (!is_quote) begin
            scan_nxt = chk_scan;
            mpos_nxt = chk_pos;
          end
        end
        default: scan_nxt = pls_pkg::SC_CODE;
      endcase
    end

    evt.code_nxt = (scan_nxt == pls_pkg::SC_CODE);
  end

  // Prefetch the stored byte at the next match position
  assign rd_addr = step ? mpos_nxt[pls_pkg::MK_IDX_W-1:0] : mpos_r[pls_pkg::MK_IDX_W-1:0];

  pls_marker_ram u_marker_ram (
    .clk   (clk),
    .we    (step && wr_en),
    .waddr (wr_addr),
    .wdata (c),
    .raddr (rd_addr),
    .rdata (mk_rd)
  );

  // Advance lexical state on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= pls_pkg::SC_CODE;
      esc_r  <= 1'b0;
      mpos_r <= '0;
      mcnt_r <= '0;
    end else if (step) begin
      scan_r <= scan_nxt;
      esc_r  <= esc_nxt;
      mpos_r <= mpos_nxt;
      mcnt_r <= mcnt_nxt;
    end
  end

endmodule

[src/pls_sub.sv]
// Brace depth counter and sub-name tracker that build the result beat.
module pls_sub (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pls_pkg::pls_item_t    item,
  input  pls_pkg::pls_lex_evt_t evt,
  output pls_pkg::pls_result_t  res
);

`include "perl_lexical_scanner_defines.svh"

  logic [pls_pkg::DEPTH_BITS-1:0] depth_r, depth_nxt, d;
  pls_pkg::sub_state_t            ss_r, ss_nxt, ss, ss_mid;
  logic [1:0]                     ki_r, ki_nxt, ki, ki_mid;
  logic [31:0]                    hs_r, hs_nxt, hs;
  logic [31:0]                    he_r, he_nxt, he;
  logic [15:0]                    hp_r, hp_nxt, hp;
  logic [7:0]                     c;

  assign c = item.ch;

  // Take reset values when the beat asks for a restart
  always_comb begin
    d  = item.restart ? '0 : depth_r;
    ss = item.restart ? pls_pkg::SUB_IDLE : ss_r;
    ki = item.restart ? 2'd0 : ki_r;
    hs = item.restart ? 32'd0 : hs_r;
    he = item.restart ? 32'd0 : he_r;
    hp = item.restart ? 16'd0 : hp_r;
  end

  // Update depth, report sub open and close, then watch for sub NAME
  always_comb begin
    depth_nxt = d;
    ss_mid    = ss;
    ki_mid    = ki;
    hs_nxt    = hs;
    he_nxt    = he;
    hp_nxt    = hp;
    res       = '0;
    res.italic = evt.italic;

    if (evt.brace_open) begin
      if ((d == '0) && (ss == pls_pkg::SUB_TRAIL)) begin
        res.func_open  = 1'b1;
        res.name_start = hs;
        res.name_end   = he;
        res.name_page  = hp;
        ki_mid         = 2'd0;
        ss_mid         = pls_pkg::SUB_BODY;
      end
      if (d != '1) begin
        depth_nxt = d + 1'b1;
      end
    end

    if (evt.brace_close && (d != '0)) begin
      depth_nxt = d - 1'b1;
      if ((d == pls_pkg::DEPTH_BITS'(1)) && (ss == pls_pkg::SUB_BODY)) begin
        res.func_close = 1'b1;
        ss_mid         = pls_pkg::SUB_IDLE;
      end
    end

    ss_nxt = ss_mid;
    ki_nxt = ki_mid;
    if (evt.code_nxt && (depth_nxt == '0)) begin
      case (ss_mid)
        pls_pkg::SUB_IDLE: begin
          if (c == pls_pkg::CH_LOW_S) begin
            ki_nxt = 2'd1;
            ss_nxt = pls_pkg::SUB_KEYWORD;
            hp_nxt = item.page;
          end
        end
        pls_pkg::SUB_KEYWORD: begin
          if ((ki_mid != 2'd3) && (c == pls_pkg::kw_char(ki_mid))) begin
            ki_nxt = ki_mid + 2'd1;
            if (ki_mid == 2'd2) ss_nxt = pls_pkg::SUB_LEAD;
          end else begin
            ss_nxt = pls_pkg::SUB_IDLE;
          end
        end
        pls_pkg::SUB_LEAD: begin
          if (!pls_pkg::is_space(c)) begin
            if (pls_pkg::is_alpha(c)) begin
              hp_nxt = item.page;
              hs_nxt = item.char_position;
              ki_nxt = 2'd0;
              ss_nxt = pls_pkg::SUB_NAME;
            end else begin
              ss_nxt = pls_pkg::SUB_IDLE;
            end
          end
        end
        pls_pkg::SUB_NAME: begin
          if (!(pls_pkg::is_alnum(c) || (c == pls_pkg::CH_USCORE))) begin
            he_nxt = item.char_position - 32'd1;
            ss_nxt = pls_pkg::SUB_TRAIL;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance tracker state on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      ss_r    <= pls_pkg::SUB_IDLE;
      ki_r    <= 2'd0;
      hs_r    <= 32'd0;
      he_r    <= 32'd0;
      hp_r    <= 16'd0;
    end else if (step) begin
      depth_r <= depth_nxt;
      ss_r    <= ss_nxt;
      ki_r    <= ki_nxt;
      hs_r    <= hs_nxt;
      he_r    <= he_nxt;
      hp_r    <= hp_nxt;
    end
  end

  `PLS_ASSERT_NOW(a_body_has_depth, clk, rst_n, (ss_r == pls_pkg::SUB_BODY), (depth_r != '0), "sub body at depth zero")
  `PLS_ASSERT_NOW(a_keyword_index, clk, rst_n, (ss_r == pls_pkg::SUB_KEYWORD), ((ki_r == 2'd1) || (ki_r == 2'd2)), "keyword index out of range")
  `PLS_ASSERT_NEXT(a_open_enters_body, clk, rst_n, (step && res.func_open), (ss_r == pls_pkg::SUB_BODY), "sub open did not enter body")

endmodule

[src/perl_lexical_scanner.sv]
// Top level of the Perl lexical scanner: input register, scanner logic, result register.
// The scanner takes one source byte per beat and returns one result beat per byte:
// an italic flag for comment text, a func_open pulse with the sub name's start,
// end and page when a named sub body opens at brace depth zero, and a func_close
// pulse when that body's brace closes. Each accepted byte waits in the input register
// while the lexer and sub tracker work on it, and its result moves into the result
// register once the result slot is free. A new byte is accepted every cycle while
// in_stall is low; in_stall rises only while a byte waits in the input register behind
// a stalled result. The rate rests on the state update of the lexer, whose here-document
// terminator compare reads a byte from the marker store prefetched on the previous
// beat.
// in_restart returns all scanner state to reset before its own byte is scanned.
module perl_lexical_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic [31:0] in_char_position,
  input  logic [15:0] in_page,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_italic,
  output logic        out_func_open,
  output logic [31:0] out_name_start,
  output logic [31:0] out_name_end,
  output logic [15:0] out_name_page,
  output logic        out_func_close
);

`include "perl_lexical_scanner_defines.svh"

  pls_pkg::pls_item_t    s1_item_r;
  logic                  s1_valid_r, s1_valid_nxt;
  pls_pkg::pls_lex_evt_t evt;
  pls_pkg::pls_result_t  res;
  pls_pkg::pls_result_t  out_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  adv;
  logic                  in_take;

  // Move a beat from the input register whenever the result slot frees up
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Control of both registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.ch            <= in_ch;
      s1_item_r.char_position <= in_char_position;
      s1_item_r.page          <= in_page;
      s1_item_r.restart       <= in_restart;
    end
  end

  pls_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .evt   (evt)
  );

  pls_sub u_sub (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .evt   (evt),
    .res   (res)
  );

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_italic     = out_r.italic;
  assign out_func_open  = out_r.func_open;
  assign out_name_start = out_r.name_start;
  assign out_name_end   = out_r.name_end;
  assign out_name_page  = out_r.name_page;
  assign out_func_close = out_r.func_close;

  `PLS_ASSERT_NOW(a_open_close_exclusive, clk, rst_n, (out_valid_r && out_r.func_open),
                  (!out_r.func_close), "sub open and close on one byte")
  `PLS_ASSERT_NOW(a_span_zero_when_idle, clk, rst_n, (out_valid_r && !out_r.func_open),
                  ((out_r.name_start == 32'd0) && (out_r.name_end == 32'd0) &&
                   (out_r.name_page == 16'd0)), "name span set without sub open")
  `PLS_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, adv, out_valid_r,
                   "advanced beat missing from result register")

endmodule

[bench/testbench.sv]
// Self-checking bench for the Perl lexical scanner: generated source text, own predictor.
module testbench;

  // One queued source byte; drain holds it back until all flags have returned
  typedef struct packed {
    logic               drain;
    pls_pkg::pls_item_t beat;
  } queued_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic [31:0] in_char_position;
  logic [15:0] in_page;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic        out_italic;
  logic        out_func_open;
  logic [31:0] out_name_start;
  logic [31:0] out_name_end;
  logic [15:0] out_name_page;
  logic        out_func_close;

  perl_lexical_scanner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_char_position (in_char_position),
    .in_page          (in_page),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_italic       (out_italic),
    .out_func_open    (out_func_open),
    .out_name_start   (out_name_start),
    .out_name_end     (out_name_end),
    .out_name_page    (out_name_page),
    .out_func_close   (out_func_close)
  );

  // Source text waiting to go out, and flags predicted for bytes already taken
  queued_byte_t          src_bytes[$];
  pls_pkg::pls_result_t  flags_due[$];
  queued_byte_t          next_q;
  pls_pkg::pls_item_t    on_wire;
  pls_pkg::pls_result_t  want_beat;
  pls_pkg::pls_result_t  seen_beat;

  // Text generator state
  logic [31:0] pos_ctr;
  logic [15:0] page_ctr;
  logic        drain_next;
  logic        restart_next;
  logic        stray_restarts;
  int          heredocs_made;

  // Run statistics
  int beats_sent;
  int results_seen;
  int bad_beats;
  int opens_seen;
  int closes_seen;
  int italic_seen;

  // Predictor state: lexer, here-document terminator, sub tracker
  pls_pkg::scan_state_t            lex_st;
  logic                            esc_hold;
  logic [pls_pkg::DEPTH_BITS-1:0]  depth;
  pls_pkg::sub_state_t             sub_st;
  int unsigned                     kw_idx;
  logic [31:0]                     span_start;
  logic [31:0]                     span_end;
  logic [15:0]                     span_page;
  logic [7:0]                      marker [pls_pkg::MARKER_LEN];
  int unsigned                     mk_pos;
  int unsigned                     mk_len;

  function automatic logic blank_ch(input logic [7:0] c);
    return c == pls_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic word_ch(input logic [7:0] c);
    return letter_ch(c) || (c >= "0" && c <= "9") || c == pls_pkg::CH_USCORE;
  endfunction

  function automatic logic quote_ch(input logic [7:0] c);
    return c == pls_pkg::CH_DQUOTE || c == pls_pkg::CH_SQUOTE;
  endfunction

  function automatic logic [7:0] keyword_letter(input int unsigned i);
    logic [7:0] c;
    case (i)
      0:       c = pls_pkg::CH_LOW_S;
      1:       c = pls_pkg::CH_LOW_U;
      default: c = pls_pkg::CH_LOW_B;
    endcase
    return c;
  endfunction

  function automatic void clear_scanner();
    lex_st     = pls_pkg::SC_CODE;
    esc_hold   = 1'b0;
    depth      = '0;
    sub_st     = pls_pkg::SUB_IDLE;
    kw_idx     = 0;
    span_start = '0;
    span_end   = '0;
    span_page  = '0;
    mk_pos     = 0;
    mk_len     = 0;
    marker     = '{default: '0};
  endfunction

  // Compare one line byte against the stored terminator word
  function automatic void match_terminator(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (!quote_ch(c)) begin
      if (mk_pos < mk_len && mk_pos < pls_pkg::MARKER_LEN)
        hit = (c == marker[mk_pos[pls_pkg::MK_IDX_W-1:0]]);
      mk_pos++;
      if (!hit) begin
        if (mk_pos == mk_len + 1 && c == pls_pkg::CH_LF) begin
          lex_st = pls_pkg::SC_CODE;
        end else begin
          lex_st = pls_pkg::SC_HD;
          mk_pos = 0;
        end
      end
    end
  endfunction

  // Advance the predicted scanner by one byte and return its flags
  function automatic pls_pkg::pls_result_t lex_byte(input pls_pkg::pls_item_t it);
    pls_pkg::pls_result_t r;
    logic [7:0]           c;
    logic                 live;
    r    = '0;
    c    = it.ch;
    live = 1'b1;
    if (it.restart) clear_scanner();

    // escape handling ahead of the state update
    case (lex_st)
      pls_pkg::SC_CODE, pls_pkg::SC_STRING, pls_pkg::SC_QSTRING, pls_pkg::SC_COMMAND,
      pls_pkg::SC_VARBODY: begin
        if (esc_hold) begin
          esc_hold = 1'b0;
          live = 1'b0;
        end else if (c == pls_pkg::CH_BSLASH) begin
          esc_hold = 1'b1;
          live = 1'b0;
        end
      end
      pls_pkg::SC_HD1, pls_pkg::SC_HD2, pls_pkg::SC_VAR1, pls_pkg::SC_HDSTART: begin
        if (c == pls_pkg::CH_BSLASH && !esc_hold) begin
          esc_hold = 1'b1;
          live = 1'b0;
        end
      end
      default: ;
    endcase

    if (live) begin
      case (lex_st)
        pls_pkg::SC_CODE: begin
          case (c)
            pls_pkg::CH_DOLLAR: lex_st = pls_pkg::SC_VAR1;
            pls_pkg::CH_DQUOTE: lex_st = pls_pkg::SC_STRING;
            pls_pkg::CH_SQUOTE: lex_st = pls_pkg::SC_QSTRING;
            pls_pkg::CH_BTICK:  lex_st = pls_pkg::SC_COMMAND;
            pls_pkg::CH_LT:     lex_st = pls_pkg::SC_HD1;
            pls_pkg::CH_LBRACK: lex_st = pls_pkg::SC_RE_OPTS;
            pls_pkg::CH_HASH: begin
              lex_st = pls_pkg::SC_COMMENT;
              r.italic = 1'b1;
            end
            pls_pkg::CH_LBRACE: begin
              if (depth == '0 && sub_st == pls_pkg::SUB_TRAIL) begin
                r.func_open  = 1'b1;
                r.name_start = span_start;
                r.name_end   = span_end;
                r.name_page  = span_page;
                kw_idx = 0;
                sub_st = pls_pkg::SUB_BODY;
              end
              if (depth != {pls_pkg::DEPTH_BITS{1'b1}}) depth = depth + 1'b1;
            end
            pls_pkg::CH_RBRACE: begin
              if (depth != '0) begin
                depth = depth - 1'b1;
                if (depth == '0 && sub_st == pls_pkg::SUB_BODY) begin
                  r.func_close = 1'b1;
                  sub_st = pls_pkg::SUB_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        pls_pkg::SC_STRING:  if (c == pls_pkg::CH_DQUOTE) lex_st = pls_pkg::SC_CODE;
        pls_pkg::SC_RE_OPTS: if (c == pls_pkg::CH_RBRACK) lex_st = pls_pkg::SC_CODE;
        pls_pkg::SC_QSTRING: if (c == pls_pkg::CH_SQUOTE) lex_st = pls_pkg::SC_CODE;
        pls_pkg::SC_COMMAND: if (c == pls_pkg::CH_BTICK) lex_st = pls_pkg::SC_CODE;
        pls_pkg::SC_VARBODY: if (c == pls_pkg::CH_RBRACE) lex_st = pls_pkg::SC_CODE;
        pls_pkg::SC_COMMENT: begin
          r.italic = 1'b1;
          if (c == pls_pkg::CH_LF) lex_st = pls_pkg::SC_CODE;
        end
        pls_pkg::SC_VAR1, pls_pkg::SC_HD1: begin
          if (esc_hold) begin
            esc_hold = 1'b0;
            lex_st = pls_pkg::SC_CODE;
          end else if (lex_st == pls_pkg::SC_VAR1 && c == pls_pkg::CH_LBRACE) begin
            lex_st = pls_pkg::SC_VARBODY;
          end else if (lex_st == pls_pkg::SC_HD1 && c == pls_pkg::CH_LT) begin
            lex_st = pls_pkg::SC_HD2;
          end else begin
            lex_st = pls_pkg::SC_CODE;
          end
        end
        pls_pkg::SC_HD2: begin
          if ((esc_hold || (c != pls_pkg::CH_DASH && !blank_ch(c))) && !quote_ch(c)) begin
            esc_hold  = 1'b0;
            mk_pos    = 0;
            marker[0] = c;
            lex_st    = pls_pkg::SC_HDSTART;
          end
        end
        pls_pkg::SC_HDSTART: begin
          if ((esc_hold || !blank_ch(c)) && !quote_ch(c)) begin
            esc_hold = 1'b0;
            if (mk_pos + 1 < pls_pkg::MARKER_LEN) begin
              mk_pos++;
              marker[mk_pos[pls_pkg::MK_IDX_W-1:0]] = c;
            end
          end else begin
            mk_len = mk_pos + 1;
            mk_pos = 0;
            lex_st = pls_pkg::SC_HD;
          end
        end
        pls_pkg::SC_HD: if (c == pls_pkg::CH_LF) lex_st = pls_pkg::SC_HDSTARTLINE;
        pls_pkg::SC_HDSTARTLINE: begin
          if (!blank_ch(c)) begin
            lex_st = pls_pkg::SC_HDCHECK;
            match_terminator(c);
          end
        end
        pls_pkg::SC_HDCHECK: match_terminator(c);
        default: lex_st = pls_pkg::SC_CODE;
      endcase
    end

    // sub keyword and name tracking at depth zero in code
    if (lex_st == pls_pkg::SC_CODE && depth == '0) begin
      case (sub_st)
        pls_pkg::SUB_IDLE: begin
          if (c == pls_pkg::CH_LOW_S) begin
            kw_idx = 1;
            sub_st = pls_pkg::SUB_KEYWORD;
            span_page = it.page;
          end
        end
        pls_pkg::SUB_KEYWORD: begin
          if (kw_idx < 3 && c == keyword_letter(kw_idx)) begin
            kw_idx++;
            if (kw_idx == 3) sub_st = pls_pkg::SUB_LEAD;
          end else begin
            sub_st = pls_pkg::SUB_IDLE;
          end
        end
        pls_pkg::SUB_LEAD: begin
          if (!blank_ch(c)) begin
            if (letter_ch(c)) begin
              span_page  = it.page;
              span_start = it.char_position;
              kw_idx = 0;
              sub_st = pls_pkg::SUB_NAME;
            end else begin
              sub_st = pls_pkg::SUB_IDLE;
            end
          end
        end
        pls_pkg::SUB_NAME: begin
          if (!word_ch(c)) begin
            span_end = it.char_position - 32'd1;
            sub_st = pls_pkg::SUB_TRAIL;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- text generation

  task automatic add_byte(input logic [7:0] c);
    queued_byte_t q;
    q.drain              = drain_next;
    q.beat.ch            = c;
    q.beat.char_position = pos_ctr;
    q.beat.page          = page_ctr;
    q.beat.restart       = restart_next || (stray_restarts && $urandom_range(0, 249) == 0);
    src_bytes.push_back(q);
    drain_next   = 1'b0;
    restart_next = 1'b0;
    pos_ctr++;
    if (c == pls_pkg::CH_LF && $urandom_range(0, 29) == 0) page_ctr++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 3) == 0) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_word_ch();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'("0" + $urandom_range(0, 9));
      1:       c = pls_pkg::CH_USCORE;
      default: c = rand_letter();
    endcase
    return c;
  endfunction

  task automatic add_blank();
    case ($urandom_range(0, 5))
      0:       add_byte(8'd9);
      1:       add_byte(pls_pkg::CH_LF);
      2:       add_byte(8'd11);
      3:       add_byte(8'd12);
      4:       add_byte(8'd13);
      default: add_byte(pls_pkg::CH_SPACE);
    endcase
  endtask

  task automatic add_ident();
    int n;
    n = $urandom_range(0, 5);
    add_byte(rand_letter());
    repeat (n) add_byte(rand_word_ch());
  endtask

  // sub NAME { body } with the odd malformed keyword
  task automatic gen_sub(input int lvl);
    int k;
    case ($urandom_range(0, 9))
      0:       add_text("su");
      1:       add_text("sub9");
      default: add_text("sub");
    endcase
    k = $urandom_range(0, 3);
    repeat (k) add_blank();
    add_ident();
    if ($urandom_range(0, 5) != 0) add_blank();
    add_byte(pls_pkg::CH_LBRACE);
    k = $urandom_range(0, 3);
    repeat (k) gen_token(lvl + 1);
    add_byte(pls_pkg::CH_RBRACE);
    add_byte(pls_pkg::CH_LF);
  endtask

  // <<WORD header, body lines, then the terminator line
  task automatic gen_heredoc();
    logic [7:0] mk[$];
    logic [7:0] qc;
    int         n;
    int         cut;
    heredocs_made++;
    qc = ($urandom_range(0, 1) == 0) ? pls_pkg::CH_DQUOTE : pls_pkg::CH_SQUOTE;
    add_text("<<");
    case ($urandom_range(0, 4))
      0:       add_byte(pls_pkg::CH_DASH);
      1:       add_byte(pls_pkg::CH_SPACE);
      2:       add_byte(qc);
      3:       add_byte(pls_pkg::CH_BSLASH);
      default: ;
    endcase
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
    mk.push_back(rand_letter());
    for (int i = 1; i < n; i++) mk.push_back(rand_word_ch());
    foreach (mk[i]) add_byte(mk[i]);
    case ($urandom_range(0, 9))
      0: begin
        // escaped quote ends the word and leaves the escape pending
        add_byte(pls_pkg::CH_BSLASH);
        add_byte(pls_pkg::CH_DQUOTE);
      end
      1, 2, 3: add_byte(qc);
      default: add_byte(pls_pkg::CH_SPACE);
    endcase
    add_byte(";");
    repeat ($urandom_range(0, 4)) add_byte(rand_print());
    add_byte(pls_pkg::CH_LF);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 10)) add_byte(rand_print());
      add_byte(pls_pkg::CH_LF);
    end
    cut = (n > pls_pkg::MARKER_LEN) ? pls_pkg::MARKER_LEN : n;
    // near misses: word plus a trailing byte, a cut word, or the untruncated long word
    if ($urandom_range(0, 4) == 0 || n > pls_pkg::MARKER_LEN) begin
      case ($urandom_range(0, 2))
        0: for (int i = 0; i < n; i++) add_byte(mk[i]);
        1: for (int i = 0; i + 1 < cut; i++) add_byte(mk[i]);
        default: begin
          for (int i = 0; i < cut; i++) add_byte(mk[i]);
          add_byte(rand_print());
        end
      endcase
      add_byte(pls_pkg::CH_LF);
    end
    add_byte(pls_pkg::CH_LF);
    if ($urandom_range(0, 3) == 0) begin
      add_byte(pls_pkg::CH_SPACE);
      add_byte(8'd9);
    end
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 7) == 0) add_byte(qc);
      add_byte(mk[i]);
    end
    if ($urandom_range(0, 5) == 0) add_byte(qc);
    add_byte(pls_pkg::CH_LF);
  endtask

  task automatic gen_quoted(input logic [7:0] qc);
    logic [7:0] c;
    int         n;
    n = $urandom_range(0, 8);
    add_byte(qc);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        add_byte(pls_pkg::CH_BSLASH);
        add_byte(($urandom_range(0, 1) == 0) ? qc : rand_print());
      end else begin
        c = rand_print();
        if (c == qc || c == pls_pkg::CH_BSLASH) c = "x";
        add_byte(c);
      end
    end
    add_byte(qc);
  endtask

  task automatic gen_comment();
    add_byte(pls_pkg::CH_HASH);
    repeat ($urandom_range(0, 10)) add_byte(rand_print());
    add_byte(pls_pkg::CH_LF);
  endtask

  task automatic gen_var();
    add_byte(pls_pkg::CH_DOLLAR);
    case ($urandom_range(0, 4))
      0: begin
        add_byte(pls_pkg::CH_LBRACE);
        add_ident();
        add_byte(pls_pkg::CH_RBRACE);
      end
      1: begin
        add_byte(pls_pkg::CH_BSLASH);
        add_byte(rand_print());
      end
      default: add_ident();
    endcase
  endtask

  task automatic gen_bracket();
    logic [7:0] c;
    add_byte(pls_pkg::CH_LBRACK);
    repeat ($urandom_range(0, 6)) begin
      c = rand_print();
      if (c == pls_pkg::CH_RBRACK) c = "y";
      add_byte(c);
    end
    add_byte(pls_pkg::CH_RBRACK);
  endtask

  task automatic gen_block(input int lvl);
    if ($urandom_range(0, 9) == 0) begin
      add_byte(pls_pkg::CH_RBRACE);
    end else begin
      add_byte(pls_pkg::CH_LBRACE);
      repeat ($urandom_range(0, 3)) gen_token(lvl);
      add_byte(pls_pkg::CH_RBRACE);
    end
  endtask

  task automatic gen_words();
    add_ident();
    case ($urandom_range(0, 3))
      0:       add_text(" < 1;");
      1:       add_byte(";");
      2:       add_blank();
      default: add_byte(pls_pkg::CH_SPACE);
    endcase
  endtask

  // Pick one construct; deeper levels avoid further nesting
  task automatic gen_token(input int lvl);
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) pos_ctr = $urandom();
    if ($urandom_range(0, 49) == 0) page_ctr = 16'($urandom_range(0, 65535));
    if (pick < 22 && lvl < 2) begin
      gen_sub(lvl);
    end else if (pick < 34) begin
      gen_heredoc();
    end else if (pick < 46) begin
      case ($urandom_range(0, 2))
        0:       gen_quoted(pls_pkg::CH_DQUOTE);
        1:       gen_quoted(pls_pkg::CH_SQUOTE);
        default: gen_quoted(pls_pkg::CH_BTICK);
      endcase
    end else if (pick < 54) begin
      gen_comment();
    end else if (pick < 62) begin
      gen_var();
    end else if (pick < 68) begin
      gen_bracket();
    end else if (pick < 76 && lvl < 2) begin
      gen_block(lvl + 1);
    end else if (pick < 81) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      gen_words();
    end
  endtask

  task automatic report_bad(input string why, input pls_pkg::pls_result_t want,
                            input pls_pkg::pls_result_t got);
    if (bad_beats < 10) begin
      $display("%s at result %0d: expected italic=%0b open=%0b start=%h end=%h page=%h close=%0b",
               why, results_seen, want.italic, want.func_open, want.name_start,
               want.name_end, want.name_page, want.func_close);
      $display("    got italic=%0b open=%0b start=%h end=%h page=%h close=%0b",
               got.italic, got.func_open, got.name_start, got.name_end, got.name_page,
               got.func_close);
    end
    bad_beats++;
  endtask

  // ---------------------------------------------------------------- clock, driver, monitor

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present queued bytes; hold a stalled beat, idle at random outside the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_ch            <= '0;
      in_char_position <= '0;
      in_page          <= '0;
      in_restart       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        flags_due.push_back(lex_byte(on_wire));
        beats_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (src_bytes.size() != 0 && !(src_bytes[0].drain && flags_due.size() != 0) &&
            ((beats_sent >= 400 && beats_sent < 800) || $urandom_range(0, 99) >= 31)) begin
          next_q  = src_bytes.pop_front();
          on_wire = next_q.beat;
          in_valid         <= 1'b1;
          in_ch            <= on_wire.ch;
          in_char_position <= on_wire.char_position;
          in_page          <= on_wire.page;
          in_restart       <= on_wire.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, calm for a stretch of results
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !(results_seen >= 1000 && results_seen < 1400) &&
                   ($urandom_range(0, 99) < 31);
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_beat = {out_italic, out_func_open, out_name_start, out_name_end, out_name_page,
                   out_func_close};
      if (flags_due.size() == 0) begin
        report_bad("unexpected result", '0, seen_beat);
      end else begin
        want_beat = flags_due.pop_front();
        if (seen_beat.italic !== want_beat.italic ||
            seen_beat.func_open !== want_beat.func_open ||
            seen_beat.name_start !== want_beat.name_start ||
            seen_beat.name_end !== want_beat.name_end ||
            seen_beat.name_page !== want_beat.name_page ||
            seen_beat.func_close !== want_beat.func_close)
          report_bad("wrong result", want_beat, seen_beat);
      end
      if (seen_beat.italic === 1'b1) italic_seen++;
      if (seen_beat.func_open === 1'b1) opens_seen++;
      if (seen_beat.func_close === 1'b1) closes_seen++;
      results_seen++;
    end
  end

  initial begin
    #18000000;
    $display("timeout with %0d bytes queued and %0d results outstanding",
             src_bytes.size(), flags_due.size());
    $display("perl_lexical_scanner verification failed");
    $finish;
  end

  initial begin
    int start;
    logic mid_drain;
    rst_n            = 1'b0;
    beats_sent       = 0;
    results_seen     = 0;
    bad_beats        = 0;
    opens_seen       = 0;
    closes_seen      = 0;
    italic_seen      = 0;
    heredocs_made    = 0;
    drain_next       = 1'b0;
    restart_next     = 1'b0;
    stray_restarts   = 1'b0;
    mid_drain        = 1'b0;
    clear_scanner();

    // Directed: restart on a zero byte, a sub name wrapping the position counter,
    // stray close brace, comment with CR, quoted heredoc word, high bytes, escapes
    pos_ctr      = '0;
    page_ctr     = '0;
    restart_next = 1'b1;
    add_byte(8'h00);
    pos_ctr  = 32'hFFFF_FFFB;
    page_ctr = 16'hFFFF;
    add_text("sub");
    add_byte(8'd11);
    add_text("Q {}}");
    add_byte(8'hFF);
    add_text("#c");
    add_byte(8'd13);
    add_byte(pls_pkg::CH_LF);
    add_text("<<\"E\"\n\tE\n");
    add_byte(8'h80);
    add_byte(pls_pkg::CH_BTICK);
    add_byte(pls_pkg::CH_BSLASH);
    add_byte(pls_pkg::CH_BTICK);
    add_byte(pls_pkg::CH_BTICK);

    // Random source text, with one pause for all flags mid-way
    drain_next     = 1'b1;
    stray_restarts = 1'b1;
    pos_ctr        = 32'hFFFF_FF00;
    start          = src_bytes.size();
    while (src_bytes.size() - start < 1750) begin
      if (!mid_drain && src_bytes.size() - start > 875) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end
      gen_token(0);
    end
    stray_restarts = 1'b0;

    // Nested braces and a stray close after a restart, then a sub must still be found
    drain_next   = 1'b1;
    restart_next = 1'b1;
    add_text("{{{}}}}sub deep {}\n");

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (src_bytes.size() != 0 || in_valid || flags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("scanned %0d bytes of generated Perl text with %0d heredocs, nesting and restarts",
             beats_sent, heredocs_made);
    $display("under random stalls; saw %0d sub opens, %0d closes, %0d comment bytes, %0d bad",
             opens_seen, closes_seen, italic_seen, bad_beats);
    if (bad_beats == 0 && flags_due.size() == 0) begin
      $display("perl_lexical_scanner verification clean");
    end else begin
      $display("perl_lexical_scanner verification failed");
    end
    $finish;
  end

endmodule
